### hw/rtl/byte_ring_fifo_core_defines.svh
// assertion macros for the byte ring fifo core
// no dependencies, included by the modules that carry assertions
`ifndef BYTE_RING_FIFO_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_CORE_DEFINES_SVH

// consequent in the same cycle
`define BRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the following cycle
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/brf_pkg.sv
// shared types, codes and defaults for the byte ring fifo core
// no dependencies
package brf_pkg;

   localparam int DEPTH_DEFAULT     = 1024;
   localparam int MAX_RUN_DEFAULT   = 64;
   localparam int ENQ_BYTES_DEFAULT = 8;

   localparam int ADDR_W  = 16;
   localparam int LEN_W   = 7;
   localparam int DATA_W  = 64;
   localparam int COUNT_W = 10;
   localparam int REQ_W   = 3;
   localparam int STAT_W  = 2;

   localparam logic [REQ_W-1:0] REQ_ENQ   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEQ   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SKIP  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_ROOM = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_LEN = 2'd2;

   typedef enum logic [1:0] {
      CMD_REPORT,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WRITE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [STAT_W-1:0]   status;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    length;
      logic [DATA_W-1:0]   data;
      logic [COUNT_W-1:0]  used;
      logic [COUNT_W-1:0]  free;
   } cmd_type;

endpackage

### hw/rtl/byte_ring_fifo_core.sv
// byte ring fifo core, top level: front end, command queue, back end
// uses brf_pkg, brf_front, brf_queue and brf_back
//
// a request is taken at a rising edge with start high and busy low; it
// carries req_type (enqueue, dequeue, peek, skip, clear), req_length and up
// to eight bytes in req_enq_bytes. the ring holds DEPTH-1 bytes.
// every result is shown for one cycle with rsp_valid high and is taken at
// the edge that ends it; the receiver cannot stall. a dequeue or peek of n
// bytes gives n results back to back, rsp_last on the n-th; any other
// request gives one result with rsp_last set.
// the front end checks the request and updates pointers and fill count in
// the accepting cycle and queues a command (two entries); busy is high
// while that queue is full.
// the back end takes a command from the queue while idle, then writes or
// reads the bytes of an enqueue, dequeue or peek one after another in its
// write or read state; every other command is finished when it is taken.
// reset empties the ring and the queue; the byte store is not cleared and
// only bytes that were written are ever read.
module byte_ring_fifo_core #(
   parameter int DEPTH     = brf_pkg::DEPTH_DEFAULT,
   parameter int MAX_RUN   = brf_pkg::MAX_RUN_DEFAULT,
   parameter int ENQ_BYTES = brf_pkg::ENQ_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [brf_pkg::REQ_W-1:0]     req_type,
   input  logic [brf_pkg::LEN_W-1:0]     req_length,
   input  logic [brf_pkg::DATA_W-1:0]    req_enq_bytes,
   output logic                          rsp_valid,
   output logic [brf_pkg::STAT_W-1:0]    rsp_status,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_data_valid,
   output logic                          rsp_last,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_free_count
);

   brf_pkg::cmd_type front_cmd, q_head;
   logic accept, q_full, q_empty, q_pop;

   assign busy   = q_full;
   assign accept = start && !q_full;

   brf_front #(
      .DEPTH     (DEPTH),
      .MAX_RUN   (MAX_RUN),
      .ENQ_BYTES (ENQ_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_length    (req_length),
      .req_enq_bytes (req_enq_bytes),
      .cmd           (front_cmd)
   );

   brf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   brf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .empty          (q_empty),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_data_valid (rsp_data_valid),
      .rsp_last       (rsp_last),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count)
   );

endmodule

### hw/rtl/brf_front.sv
// front end: accepts requests, keeps pointers and fill count, classifies
// each request into a command for the back end; uses brf_pkg
module brf_front #(
   parameter int DEPTH     = brf_pkg::DEPTH_DEFAULT,
   parameter int MAX_RUN   = brf_pkg::MAX_RUN_DEFAULT,
   parameter int ENQ_BYTES = brf_pkg::ENQ_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [brf_pkg::REQ_W-1:0]        req_type,
   input  logic [brf_pkg::LEN_W-1:0]        req_length,
   input  logic [brf_pkg::DATA_W-1:0]       req_enq_bytes,
   output brf_pkg::cmd_type                 cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = PTR_W + 8;
   localparam int SUM_W = PTR_W + 1;

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] count_ff, count_in;

   logic [CMP_W-1:0] n_w, cnt_w, cap_w, free_w, new_cnt_w;
   logic [SUM_W-1:0] rd_sum, wr_sum;

   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] lim;
      lim = SUM_W'(DEPTH);
      return (sum >= lim) ? PTR_W'(sum - lim) : PTR_W'(sum);
   endfunction

   always_comb begin
      n_w    = CMP_W'(req_length);
      cnt_w  = CMP_W'(count_ff);
      cap_w  = CMP_W'(DEPTH - 1);
      free_w = cap_w - cnt_w;
      rd_sum = {1'b0, rd_ptr_ff} + SUM_W'(req_length);
      wr_sum = {1'b0, wr_ptr_ff} + SUM_W'(req_length);

      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;

      cmd        = '0;
      cmd.kind   = brf_pkg::CMD_REPORT;
      cmd.status = brf_pkg::ST_OK;
      cmd.length = req_length;
      cmd.data   = req_enq_bytes;

      case (req_type)
         brf_pkg::REQ_ENQ: begin
            if (n_w > CMP_W'(ENQ_BYTES)) begin
               cmd.status = brf_pkg::ST_BAD_LEN;
            end else if (n_w > free_w) begin
               cmd.status = brf_pkg::ST_NO_ROOM;
            end else if (n_w != '0) begin
               cmd.kind  = brf_pkg::CMD_WRITE;
               cmd.addr  = brf_pkg::ADDR_W'(wr_ptr_ff);
               wr_ptr_in = wrap_ptr(wr_sum);
               count_in  = PTR_W'(cnt_w + n_w);
            end
         end
         brf_pkg::REQ_DEQ, brf_pkg::REQ_PEEK, brf_pkg::REQ_SKIP: begin
            if (n_w > CMP_W'(MAX_RUN)) begin
               cmd.status = brf_pkg::ST_BAD_LEN;
            end else if (n_w > cnt_w) begin
               cmd.status = brf_pkg::ST_NO_ROOM;
            end else if (n_w != '0) begin
               cmd.addr = brf_pkg::ADDR_W'(rd_ptr_ff);
               if (req_type != brf_pkg::REQ_SKIP) begin
                  cmd.kind = brf_pkg::CMD_READ;
               end
               if (req_type != brf_pkg::REQ_PEEK) begin
                  rd_ptr_in = wrap_ptr(rd_sum);
                  count_in  = PTR_W'(cnt_w - n_w);
               end
            end
         end
         brf_pkg::REQ_CLEAR: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            count_in  = '0;
         end
         default: begin
            cmd.status = brf_pkg::ST_BAD_LEN;
         end
      endcase

      new_cnt_w = CMP_W'(count_in);
      cmd.used  = brf_pkg::COUNT_W'(new_cnt_w);
      cmd.free  = brf_pkg::COUNT_W'(cap_w - new_cnt_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/brf_queue.sv
// two-entry command queue between front and back end
// uses brf_pkg for the command type
module brf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brf_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output brf_pkg::cmd_type  head,
   output logic              empty,
   output logic              full
);

   brf_pkg::cmd_type slot_ff [2];
   logic       wr_sel_ff, rd_sel_ff;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   assign head  = slot_ff[rd_sel_ff];
   assign empty = (fill_ff == 2'd0);
   assign full  = (fill_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_sel_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_sel_ff <= ~wr_sel_ff;
         end
         if (pop) begin
            rd_sel_ff <= ~rd_sel_ff;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_sel_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/brf_back.sv
// back end: byte store, write and read sequencer, response registers
// uses brf_pkg and byte_ring_fifo_core_defines.svh
`include "byte_ring_fifo_core_defines.svh"

module brf_back #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brf_pkg::cmd_type              head,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [brf_pkg::STAT_W-1:0]    rsp_status,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_data_valid,
   output logic                          rsp_last,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [brf_pkg::COUNT_W-1:0]   rsp_free_count
);

   localparam int PTR_W = $clog2(DEPTH);

   brf_pkg::back_state_type state_ff, state_in;
   brf_pkg::cmd_type        cur_ff;

   logic [PTR_W-1:0]             addr_ff, addr_in;
   logic [brf_pkg::LEN_W-1:0]    remain_ff, remain_in;
   logic [brf_pkg::DATA_W-1:0]   shift_ff, shift_in;

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;
   logic       mem_we, mem_re;

   logic                         emit, emit_dv, emit_last;
   logic [brf_pkg::STAT_W-1:0]   emit_status;
   logic [brf_pkg::COUNT_W-1:0]  emit_used, emit_free;

   logic                         valid_ff, dv_ff, last_ff;
   logic [brf_pkg::STAT_W-1:0]   status_ff;
   logic [brf_pkg::COUNT_W-1:0]  used_ff, free_ff;

   logic [PTR_W-1:0] addr_step;
   assign addr_step = (addr_ff == PTR_W'(DEPTH - 1)) ? '0 : addr_ff + PTR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brf_pkg::BK_IDLE: begin
            if (!empty) begin
               case (head.kind)
                  brf_pkg::CMD_WRITE: state_in = brf_pkg::BK_WRITE;
                  brf_pkg::CMD_READ:  state_in = brf_pkg::BK_READ;
                  default:            state_in = brf_pkg::BK_IDLE;
               endcase
            end
         end
         brf_pkg::BK_WRITE, brf_pkg::BK_READ: begin
            if (remain_ff == brf_pkg::LEN_W'(1)) begin
               state_in = brf_pkg::BK_IDLE;
            end
         end
         default: state_in = brf_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop         = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      emit        = 1'b0;
      emit_dv     = 1'b0;
      emit_last   = 1'b1;
      emit_status = cur_ff.status;
      emit_used   = cur_ff.used;
      emit_free   = cur_ff.free;
      addr_in     = addr_ff;
      remain_in   = remain_ff;
      shift_in    = shift_ff;
      case (state_ff)
         brf_pkg::BK_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               addr_in   = PTR_W'(head.addr);
               remain_in = head.length;
               shift_in  = head.data;
               if (head.kind == brf_pkg::CMD_REPORT) begin
                  emit        = 1'b1;
                  emit_status = head.status;
                  emit_used   = head.used;
                  emit_free   = head.free;
               end
            end
         end
         brf_pkg::BK_WRITE: begin
            mem_we    = 1'b1;
            addr_in   = addr_step;
            remain_in = remain_ff - brf_pkg::LEN_W'(1);
            shift_in  = shift_ff >> 8;
            emit      = (remain_ff == brf_pkg::LEN_W'(1));
         end
         brf_pkg::BK_READ: begin
            mem_re    = 1'b1;
            addr_in   = addr_step;
            remain_in = remain_ff - brf_pkg::LEN_W'(1);
            emit      = 1'b1;
            emit_dv   = 1'b1;
            emit_last = (remain_ff == brf_pkg::LEN_W'(1));
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::BK_IDLE;
         valid_ff <= 1'b0;
         dv_ff    <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= emit;
         if (emit) begin
            dv_ff   <= emit_dv;
            last_ff <= emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
      shift_ff  <= shift_in;
      if (pop) begin
         cur_ff <= head;
      end
      if (emit) begin
         status_ff <= emit_status;
         used_ff   <= emit_used;
         free_ff   <= emit_free;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[addr_ff] <= shift_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store_ff[addr_ff];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_data_byte  = dv_ff ? rd_data_ff : 8'd0;
   assign rsp_data_valid = dv_ff;
   assign rsp_last       = last_ff;
   assign rsp_used_count = used_ff;
   assign rsp_free_count = free_ff;

   `BRF_ASSERT_NEXT(burst_gapless, clock, reset, valid_ff && !last_ff, valid_ff,
      "read burst broken before its last byte")
   `BRF_ASSERT_NOW(single_is_last, clock, reset, valid_ff && !dv_ff, last_ff,
      "non-data response without last flag")
   `BRF_ASSERT_NOW(run_nonzero, clock, reset,
      state_ff == brf_pkg::BK_READ || state_ff == brf_pkg::BK_WRITE,
      remain_ff != '0, "sequencer running with zero bytes left")
   `BRF_ASSERT_NOW(no_pop_busy, clock, reset, state_ff != brf_pkg::BK_IDLE, !pop,
      "command taken while sequencer busy")

endmodule

### test/tb_top.sv
// self-checking bench for byte_ring_fifo_core: directed table, random requests, fill and drain,
// more random requests, all scored against a behavioural ring model; depends on brf_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;

   localparam int RING_DEPTH   = brf_pkg::DEPTH_DEFAULT;
   localparam int CAPACITY     = RING_DEPTH - 1;
   localparam int RUN_MAX      = brf_pkg::MAX_RUN_DEFAULT;
   localparam int ENQ_MAX      = brf_pkg::ENQ_BYTES_DEFAULT;
   localparam int LATENCY_WAIT = 2 * (RUN_MAX + 2);
   localparam int STALL_LIMIT  = 4000;
   localparam int PLAN_LEN     = 25;
   localparam int MIXED_COUNT  = 35;
   localparam int FILL_TARGET  = 192;

   localparam logic [brf_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd5;
   localparam logic [brf_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd6;
   localparam logic [brf_pkg::REQ_W-1:0] REQ_SPARE_C = 3'd7;

   typedef struct packed {
      logic [brf_pkg::STAT_W-1:0]  status;
      logic [7:0]                  data;
      logic                        dvalid;
      logic                        last;
      logic [brf_pkg::COUNT_W-1:0] used;
      logic [brf_pkg::COUNT_W-1:0] free;
   } ring_result_type;

   typedef struct packed {
      logic [brf_pkg::REQ_W-1:0]   kind;
      logic [brf_pkg::LEN_W-1:0]   n;
      logic [brf_pkg::DATA_W-1:0]  bytes;
      logic                        fixed;
      logic [brf_pkg::STAT_W-1:0]  st;
      logic [brf_pkg::COUNT_W-1:0] used;
   } plan_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [brf_pkg::REQ_W-1:0]    req_type = '0;
   logic [brf_pkg::LEN_W-1:0]    req_length = '0;
   logic [brf_pkg::DATA_W-1:0]   req_enq_bytes = '0;
   logic                         rsp_valid;
   logic [brf_pkg::STAT_W-1:0]   rsp_status;
   logic [7:0]                   rsp_data_byte;
   logic                         rsp_data_valid;
   logic                         rsp_last;
   logic [brf_pkg::COUNT_W-1:0]  rsp_used_count;
   logic [brf_pkg::COUNT_W-1:0]  rsp_free_count;

   // ring model state
   logic [7:0]      ring_bytes [0:RING_DEPTH-1];
   int              rd_idx = 0;
   int              wr_idx = 0;
   int              fill = 0;
   ring_result_type owed_results [$];

   int errors = 0;
   int rsp_seen = 0;
   int burst_left = 1;

   plan_row_type plan [PLAN_LEN] = '{
      '{brf_pkg::REQ_CLEAR, 7'd0,   64'd0,      1'b1, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_DEQ,   7'd1,   64'd0,      1'b1, brf_pkg::ST_NO_ROOM, 10'd0},
      '{brf_pkg::REQ_PEEK,  7'd64,  64'd0,      1'b1, brf_pkg::ST_NO_ROOM, 10'd0},
      '{brf_pkg::REQ_ENQ,   7'd9,   {64{1'b1}}, 1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{brf_pkg::REQ_ENQ,   7'd127, {64{1'b1}}, 1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{brf_pkg::REQ_SKIP,  7'd65,  64'd0,      1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{brf_pkg::REQ_DEQ,   7'd127, 64'd0,      1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{REQ_SPARE_A,        7'd3,   {64{1'b1}}, 1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{REQ_SPARE_B,        7'd0,   64'd0,      1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{REQ_SPARE_C,        7'd127, {64{1'b1}}, 1'b1, brf_pkg::ST_BAD_LEN, 10'd0},
      '{brf_pkg::REQ_ENQ,   7'd0,   {64{1'b1}}, 1'b1, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_ENQ,   7'd8,   {64{1'b1}}, 1'b1, brf_pkg::ST_OK,      10'd8},
      '{brf_pkg::REQ_ENQ,   7'd8,   64'h0123_4567_89AB_CDEF, 1'b1, brf_pkg::ST_OK, 10'd16},
      '{brf_pkg::REQ_PEEK,  7'd16,  64'd0,      1'b0, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_PEEK,  7'd0,   64'd0,      1'b1, brf_pkg::ST_OK,      10'd16},
      '{brf_pkg::REQ_DEQ,   7'd3,   64'd0,      1'b0, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_SKIP,  7'd5,   64'd0,      1'b1, brf_pkg::ST_OK,      10'd8},
      '{brf_pkg::REQ_DEQ,   7'd9,   64'd0,      1'b1, brf_pkg::ST_NO_ROOM, 10'd8},
      '{brf_pkg::REQ_ENQ,   7'd5,   64'h0000_00A5_5AC3_3C00, 1'b1, brf_pkg::ST_OK, 10'd13},
      '{brf_pkg::REQ_DEQ,   7'd13,  64'd0,      1'b0, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_ENQ,   7'd8,   64'h8000_0000_0000_0001, 1'b1, brf_pkg::ST_OK, 10'd8},
      '{brf_pkg::REQ_CLEAR, 7'd0,   64'd0,      1'b1, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_SKIP,  7'd0,   64'd0,      1'b1, brf_pkg::ST_OK,      10'd0},
      '{brf_pkg::REQ_ENQ,   7'd1,   64'h0000_0000_0000_0080, 1'b1, brf_pkg::ST_OK, 10'd1},
      '{brf_pkg::REQ_ENQ,   7'd8,   64'd0,      1'b1, brf_pkg::ST_OK,      10'd9}
   };

   byte_ring_fifo_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_length     (req_length),
      .req_enq_bytes  (req_enq_bytes),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_data_valid (rsp_data_valid),
      .rsp_last       (rsp_last),
      .rsp_used_count (rsp_used_count),
      .rsp_free_count (rsp_free_count)
   );

   always #10 clock = ~clock;

   function automatic void owe(input logic [brf_pkg::STAT_W-1:0] status,
                               input logic [7:0] data, input logic dvalid,
                               input logic last);
      ring_result_type r;
      r.status = status;
      r.data   = data;
      r.dvalid = dvalid;
      r.last   = last;
      r.used   = fill[brf_pkg::COUNT_W-1:0];
      r.free   = brf_pkg::COUNT_W'(CAPACITY - fill);
      owed_results.push_back(r);
   endfunction

   task automatic ring_apply(input logic [brf_pkg::REQ_W-1:0] kind,
                             input logic [brf_pkg::LEN_W-1:0] n,
                             input logic [brf_pkg::DATA_W-1:0] bytes);
      int pos;
      logic [7:0] got [$];
      case (kind)
         brf_pkg::REQ_ENQ: begin
            if (n > ENQ_MAX) begin
               owe(brf_pkg::ST_BAD_LEN, 8'd0, 1'b0, 1'b1);
            end else if (n > CAPACITY - fill) begin
               owe(brf_pkg::ST_NO_ROOM, 8'd0, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  ring_bytes[wr_idx] = bytes[8*i +: 8];
                  wr_idx = (wr_idx + 1) % RING_DEPTH;
               end
               fill += n;
               owe(brf_pkg::ST_OK, 8'd0, 1'b0, 1'b1);
            end
         end
         brf_pkg::REQ_DEQ, brf_pkg::REQ_PEEK, brf_pkg::REQ_SKIP: begin
            if (n > RUN_MAX) begin
               owe(brf_pkg::ST_BAD_LEN, 8'd0, 1'b0, 1'b1);
            end else if (n > fill) begin
               owe(brf_pkg::ST_NO_ROOM, 8'd0, 1'b0, 1'b1);
            end else if (n == 0) begin
               owe(brf_pkg::ST_OK, 8'd0, 1'b0, 1'b1);
            end else if (kind == brf_pkg::REQ_SKIP) begin
               rd_idx = (rd_idx + n) % RING_DEPTH;
               fill -= n;
               owe(brf_pkg::ST_OK, 8'd0, 1'b0, 1'b1);
            end else begin
               pos = rd_idx;
               for (int i = 0; i < n; i++) begin
                  got.push_back(ring_bytes[pos]);
                  pos = (pos + 1) % RING_DEPTH;
               end
               if (kind == brf_pkg::REQ_DEQ) begin
                  rd_idx = pos;
                  fill -= n;
               end
               for (int i = 0; i < n; i++)
                  owe(brf_pkg::ST_OK, got[i], 1'b1, i == n - 1);
            end
         end
         brf_pkg::REQ_CLEAR: begin
            rd_idx = 0;
            wr_idx = 0;
            fill = 0;
            owe(brf_pkg::ST_OK, 8'd0, 1'b0, 1'b1);
         end
         default: begin
            owe(brf_pkg::ST_BAD_LEN, 8'd0, 1'b0, 1'b1);
         end
      endcase
   endtask

   // drive one request, hold it until taken, then maybe leave a gap
   task automatic issue(input logic [brf_pkg::REQ_W-1:0] kind,
                        input logic [brf_pkg::LEN_W-1:0] n,
                        input logic [brf_pkg::DATA_W-1:0] bytes, input logic fixed,
                        input logic [brf_pkg::STAT_W-1:0] st,
                        input logic [brf_pkg::COUNT_W-1:0] used);
      ring_result_type typed;
      int gap;
      req_type <= kind;
      req_length <= n;
      req_enq_bytes <= bytes;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      ring_apply(kind, n, bytes);
      if (fixed) begin
         typed = '{st, 8'd0, 1'b0, 1'b1, used, brf_pkg::COUNT_W'(CAPACITY - used)};
         void'(owed_results.pop_back());
         owed_results.push_back(typed);
      end
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_wait(input int extra);
      start <= 1'b0;
      @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic read_len(output logic [brf_pkg::LEN_W-1:0] n);
      int avail;
      avail = (fill > RUN_MAX) ? RUN_MAX : fill;
      n = (avail == 0) ? 7'd1 : brf_pkg::LEN_W'($urandom_range(1, avail));
   endtask

   // mostly well-formed requests, some noise
   task automatic random_request();
      logic [brf_pkg::REQ_W-1:0] kind;
      logic [brf_pkg::LEN_W-1:0] n;
      logic [brf_pkg::DATA_W-1:0] bytes;
      int roll;
      roll = $urandom_range(0, 99);
      bytes = {$urandom, $urandom};
      n = brf_pkg::LEN_W'($urandom_range(1, ENQ_MAX));
      if (roll < 40) begin
         kind = brf_pkg::REQ_ENQ;
      end else if (roll < 58) begin
         kind = brf_pkg::REQ_DEQ;
         read_len(n);
      end else if (roll < 70) begin
         kind = brf_pkg::REQ_PEEK;
         read_len(n);
      end else if (roll < 80) begin
         kind = brf_pkg::REQ_SKIP;
         read_len(n);
      end else if (roll < 83) begin
         kind = brf_pkg::REQ_CLEAR;
      end else begin
         kind = brf_pkg::REQ_W'($urandom_range(0, 7));
         n = brf_pkg::LEN_W'($urandom_range(0, 127));
      end
      issue(kind, n, bytes, 1'b0, brf_pkg::ST_OK, 10'd0);
      if ($urandom_range(0, 24) == 0)
         drain_wait(0);
   endtask

   task automatic compare_field(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want) begin
         errors++;
         $display("mismatch on result %0d, %s: got %0h, expected %0h",
                  rsp_seen, what, got, want);
      end
   endtask

   // outputs are registered, so sample mid-cycle
   always @(negedge clock) begin
      ring_result_type want;
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            compare_field("unexpected result", 64'd1, 64'd0);
         end else begin
            want = owed_results.pop_front();
            compare_field("status", 64'(rsp_status), 64'(want.status));
            compare_field("data_byte", 64'(rsp_data_byte), 64'(want.data));
            compare_field("data_valid", 64'(rsp_data_valid), 64'(want.dvalid));
            compare_field("last", 64'(rsp_last), 64'(want.last));
            compare_field("used_count", 64'(rsp_used_count), 64'(want.used));
            compare_field("free_count", 64'(rsp_free_count), 64'(want.free));
         end
         rsp_seen++;
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            idle = 0;
         else
            idle++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [brf_pkg::LEN_W-1:0] n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++)
         issue(plan[i].kind, plan[i].n, plan[i].bytes, plan[i].fixed, plan[i].st,
               plan[i].used);

      for (int i = 0; i < MIXED_COUNT; i++)
         random_request();
      drain_wait(0);

      // fill part way with full words, then long reads down to empty
      while (fill < FILL_TARGET)
         issue(brf_pkg::REQ_ENQ, brf_pkg::LEN_W'(ENQ_MAX), {$urandom, $urandom}, 1'b0,
               brf_pkg::ST_OK, 10'd0);
      issue(brf_pkg::REQ_PEEK, 7'd64, 64'd0, 1'b0, brf_pkg::ST_OK, 10'd0);

      while (fill > 0) begin
         read_len(n);
         if ($urandom_range(0, 2) == 0 && fill >= RUN_MAX)
            n = brf_pkg::LEN_W'(RUN_MAX);
         issue(brf_pkg::REQ_W'($urandom_range(brf_pkg::REQ_DEQ, brf_pkg::REQ_SKIP)), n,
               {$urandom, $urandom}, 1'b0, brf_pkg::ST_OK, 10'd0);
      end
      drain_wait(0);

      for (int i = 0; i < MIXED_COUNT; i++)
         random_request();

      drain_wait(LATENCY_WAIT);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/brf_pkg.sv
hw/rtl/brf_front.sv
hw/rtl/brf_queue.sv
hw/rtl/brf_back.sv
hw/rtl/byte_ring_fifo_core.sv
test/tb_top.sv
